// File: hdl/keyed_average_pixel_blend_defines.svh
// ---------------------------------------------------------------------------
// keyed average pixel blend assertion macros
// shared property shapes for the port-level checker
// ---------------------------------------------------------------------------
`ifndef KEYED_AVERAGE_PIXEL_BLEND_DEFINES_SVH
`define KEYED_AVERAGE_PIXEL_BLEND_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define KAPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define KAPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/kapb_pkg.sv
// ---------------------------------------------------------------------------
// kapb_pkg
// shared constants, types and state codes of the keyed average pixel blend
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kapb_pkg;

    // layer limit per output pixel
    localparam int MAX_LAYERS = 16;

    // channel geometry
    localparam int NUM_CH   = 4;
    localparam int CH_W     = 8;
    localparam int CH_IDX_W = $clog2(NUM_CH);
    localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

    // accumulator widths
    localparam int SUM_W = $clog2(MAX_LAYERS * 255 + 1);
    localparam int CNT_W = $clog2(MAX_LAYERS + 1);

    // divider step counter width, one quotient bit per step
    localparam int STEP_W = $clog2(CH_W);

    // stream widths
    localparam int DATA_W = NUM_CH * CH_W;
    localparam int USER_W = 2;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] t_sums;
    typedef logic [NUM_CH-1:0][CH_W-1:0]  t_pix;

    // accumulator status seen by the sequencer
    typedef struct packed {
        logic [CNT_W-1:0] kept;
        logic             overflow;
    } t_acc_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_PUSH
    } t_state;

endpackage

`default_nettype wire

// File: hdl/kapb_accum.sv
// ---------------------------------------------------------------------------
// kapb_accum
// per-pixel channel sums, kept-layer count, layer count and overflow flag
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kapb_accum (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take,
    input  wire kapb_pkg::t_pix     i_pix,
    input  wire logic               i_clear,
    output kapb_pkg::t_sums         o_sums,
    output kapb_pkg::t_acc_stat     o_stat
);
    import kapb_pkg::*;

    t_sums            r_sums;
    logic [CNT_W-1:0] r_kept;
    logic [CNT_W-1:0] r_seen;
    logic             r_ovf;
    logic             w_white;
    logic             w_room;

    // pure white in red, green and blue is keyed out
    assign w_white = (i_pix[0] == CH_MAX) && (i_pix[1] == CH_MAX) && (i_pix[2] == CH_MAX);
    assign w_room  = (r_seen < CNT_W'(MAX_LAYERS));

    // accumulate accepted layers, clear after the result is handed off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sums <= '0;
            r_kept <= '0;
            r_seen <= '0;
            r_ovf  <= 1'b0;
        end else if (i_take) begin
            if (w_room) begin
                r_seen <= r_seen + 1'b1;
                if (!w_white) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        r_sums[c] <= r_sums[c] + SUM_W'(i_pix[c]);
                    end
                    r_kept <= r_kept + 1'b1;
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign o_sums          = r_sums;
    assign o_stat.kept     = r_kept;
    assign o_stat.overflow = r_ovf;

endmodule

`default_nettype wire

// File: hdl/kapb_div.sv
// ---------------------------------------------------------------------------
// kapb_div
// shared restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kapb_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [kapb_pkg::SUM_W-1:0]    i_dividend,
    input  wire logic [kapb_pkg::CNT_W-1:0]    i_divisor,
    output logic                               o_busy,
    output logic [kapb_pkg::CH_W-1:0]          o_quot
);
    import kapb_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [CH_W-1:0]   r_lo;
    logic [CH_W-1:0]   r_quot;
    logic [SUM_W-1:0]  w_hi;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    // quotient fits CH_W bits, so the upper dividend bits start below the divisor
    assign w_hi    = i_dividend >> CH_W;
    assign w_trial = {r_rem, r_lo[CH_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_W'(CH_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // shift-subtract datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= w_hi[CNT_W-1:0];
            r_lo   <= i_dividend[CH_W-1:0];
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_lo   <= {r_lo[CH_W-2:0], 1'b0};
            r_quot <= {r_quot[CH_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: hdl/kapb_seq.sv
// ---------------------------------------------------------------------------
// kapb_seq
// sequencer: runs the shared divider over the four channels and holds the
// output item register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kapb_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_take,
    input  wire logic                          i_last,
    input  wire kapb_pkg::t_sums               i_sums,
    input  wire kapb_pkg::t_acc_stat           i_stat,
    input  wire logic                          i_div_busy,
    input  wire logic [kapb_pkg::CH_W-1:0]     i_div_quot,
    input  wire logic                          i_m_tready,
    output logic                               o_ready,
    output logic                               o_clear,
    output logic                               o_div_start,
    output logic [kapb_pkg::SUM_W-1:0]         o_div_dividend,
    output logic                               o_m_tvalid,
    output logic [kapb_pkg::DATA_W-1:0]        o_m_tdata,
    output logic [kapb_pkg::USER_W-1:0]        o_m_tuser
);
    import kapb_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CH_IDX_W-1:0] r_ch;
    t_pix                r_quot;
    logic                r_m_tvalid;
    logic [DATA_W-1:0]   r_m_tdata;
    logic [USER_W-1:0]   r_m_tuser;
    logic                w_keyed;
    logic                w_capture;
    logic                w_push;
    logic                w_out_free;

    assign w_keyed    = (i_stat.kept == '0);
    assign w_out_free = !r_m_tvalid || i_m_tready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and control outputs
    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        o_div_start = 1'b0;
        w_capture   = 1'b0;
        w_push      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_take && i_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (w_keyed) begin
                    n_state = ST_PUSH;
                end else begin
                    o_div_start = 1'b1;
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!i_div_busy) begin
                    w_capture = 1'b1;
                    n_state   = (r_ch == CH_IDX_W'(NUM_CH - 1)) ? ST_PUSH : ST_LOAD;
                end
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    w_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_clear        = w_push;
    assign o_div_dividend = i_sums[r_ch];

    // channel pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (r_state == ST_IDLE) begin
            r_ch <= '0;
        end else if (w_capture) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    // collected quotients
    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_quot[r_ch] <= i_div_quot;
        end
    end

    // output item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_push) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_m_tdata <= w_keyed ? {DATA_W{1'b1}} : r_quot;
            r_m_tuser <= {i_stat.overflow, w_keyed};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

`default_nettype wire

// File: hdl/keyed_average_pixel_blend.sv
// Input: a layer item that is not last is taken and the block stays ready. A last item
// starts four divisions on one shared bit-serial divider, one per channel, unless all layers
// were keyed. The block is not ready again until the result is in the output register.
// Throughput: one layer per cycle within a pixel; none while the block is not ready.
// Reset: synchronous active low; clears sums, counts, sequencer state and output valid.
// ---------------------------------------------------------------------------
// keyed_average_pixel_blend
// averages co-located RGBA8 layer pixels, keying out pure white layers
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyed_average_pixel_blend (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // red_in, green_in, blue_in, alpha_in from the lowest bit up
    input  wire logic [kapb_pkg::DATA_W-1:0]   s_axis_tdata,
    // last_layer
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // red_out, green_out, blue_out, alpha_out from the lowest bit up
    output logic [kapb_pkg::DATA_W-1:0]        m_axis_tdata,
    // all_keyed, layer_overflow from the lowest bit up
    output logic [kapb_pkg::USER_W-1:0]        m_axis_tuser
);
    import kapb_pkg::*;

    logic             w_take;
    logic             w_clear;
    t_sums            w_sums;
    t_acc_stat        w_stat;
    logic             w_div_start;
    logic [SUM_W-1:0] w_div_dividend;
    logic             w_div_busy;
    logic [CH_W-1:0]  w_div_quot;

    assign w_take = s_axis_tvalid && s_axis_tready;

    // layer accumulation
    kapb_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_pix   (s_axis_tdata),
        .i_clear (w_clear),
        .o_sums  (w_sums),
        .o_stat  (w_stat)
    );

    // shared divider
    kapb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_stat.kept),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot)
    );

    // sequencer and output register
    kapb_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_last         (s_axis_tlast),
        .i_sums         (w_sums),
        .i_stat         (w_stat),
        .i_div_busy     (w_div_busy),
        .i_div_quot     (w_div_quot),
        .i_m_tready     (m_axis_tready),
        .o_ready        (s_axis_tready),
        .o_clear        (w_clear),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_div_dividend),
        .o_m_tvalid     (m_axis_tvalid),
        .o_m_tdata      (m_axis_tdata),
        .o_m_tuser      (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: hdl/kapb_checker.sv
// ---------------------------------------------------------------------------
// kapb_checker
// port-level checks of the keyed average pixel blend, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_average_pixel_blend_defines.svh"

module kapb_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic                          s_axis_tlast,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [kapb_pkg::DATA_W-1:0]   m_axis_tdata,
    input  wire logic [kapb_pkg::USER_W-1:0]   m_axis_tuser
);
    import kapb_pkg::*;

    // a stalled output item holds
    `KAPB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output item changed while stalled")

    // an all-keyed pixel comes out opaque white
    `KAPB_ASSERT_NOW(a_keyed_white, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == {DATA_W{1'b1}}, "all-keyed result is not white")

    // inside a pixel the block keeps taking layers
    `KAPB_ASSERT_NEXT(a_mid_ready, s_axis_tvalid && s_axis_tready && !s_axis_tlast, s_axis_tready, "not ready after an inner layer")

    // after the closing layer the block is not ready while the result is made
    `KAPB_ASSERT_NEXT(a_last_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "ready right after the closing layer")

endmodule

bind keyed_average_pixel_blend kapb_checker u_kapb_checker (.*);

`default_nettype wire

// File: verif/keyed_average_pixel_blend_test.sv
// ---------------------------------------------------------------------------
// keyed_average_pixel_blend_test
// drives layer pixels into the blend stream, predicts each blended output
// pixel alongside and compares every result field by field, with random
// idling on the input side and random stalls on the output side
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyed_average_pixel_blend_test;

    import kapb_pkg::*;

    localparam int       CLK_HALF    = 6;
    localparam int       RST_CYCLES  = 12;
    localparam int       ITEM_TARGET = 1850;
    localparam int       TAIL_ITEMS  = 250;
    localparam int       DRAIN_WAIT  = 60;
    localparam longint   CYCLE_LIMIT = 400000;

    // one layer pixel as it enters the block
    typedef struct packed {
        t_pix pix;
        logic last;
        logic hold;
    } layer_t;

    // one blended output pixel
    typedef struct packed {
        t_pix pix;
        logic all_keyed;
        logic overflow;
    } blend_px_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic [USER_W-1:0]   m_axis_tuser;

    layer_t              layer_q[$];
    blend_px_t           pending_pixels[$];
    layer_t              cur_layer;
    int                  err_cnt = 0;
    int                  sent_cnt = 0;
    int                  recv_cnt = 0;
    int                  send_gap = 0;
    int                  recv_stall = 0;
    longint              cycle_cnt = 0;

    // running state of the blend predictor
    logic [SUM_W-1:0]    chan_sum [NUM_CH];
    logic [CNT_W-1:0]    kept_cnt;
    logic [CNT_W-1:0]    seen_cnt;
    logic                ovf_seen;

    string               chan_name [NUM_CH] = '{"red", "green", "blue", "alpha"};

    keyed_average_pixel_blend i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // clear the running pixel
    task automatic clear_blend();
        for (int c = 0; c < NUM_CH; c++) begin
            chan_sum[c] = '0;
        end
        kept_cnt = '0;
        seen_cnt = '0;
        ovf_seen = 1'b0;
    endtask

    // fold one accepted layer into the running pixel, queue the result on a last layer
    task automatic blend_layer(input layer_t l);
        blend_px_t px;
        if (seen_cnt < CNT_W'(MAX_LAYERS)) begin
            seen_cnt = seen_cnt + 1'b1;
            if (!(l.pix[0] == CH_MAX && l.pix[1] == CH_MAX && l.pix[2] == CH_MAX)) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    chan_sum[c] = chan_sum[c] + SUM_W'(l.pix[c]);
                end
                kept_cnt = kept_cnt + 1'b1;
            end
        end else begin
            ovf_seen = 1'b1;
        end
        if (l.last) begin
            for (int c = 0; c < NUM_CH; c++) begin
                px.pix[c] = (kept_cnt != 0) ? CH_W'(chan_sum[c] / kept_cnt) : CH_MAX;
            end
            px.all_keyed = (kept_cnt == 0);
            px.overflow  = ovf_seen;
            pending_pixels.push_back(px);
            clear_blend();
        end
    endtask

    task automatic add_layer(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] a, input logic last, input logic hold);
        layer_t l;
        l.pix  = {a, b, g, r};
        l.last = last;
        l.hold = hold;
        layer_q.push_back(l);
    endtask

    // channel value leaning toward the extremes
    function automatic logic [7:0] pick_chan();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            return 8'd0;
        end else if (sel <= 2) begin
            return 8'd255;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // one pixel made of a random number of layers
    task automatic add_random_pixel(input logic hold);
        int mode;
        int n_layers;
        bit all_white;
        bit keyed;
        mode      = $urandom_range(0, 19);
        all_white = (mode <= 1);
        if (mode <= 1) begin
            n_layers = $urandom_range(1, 4);
        end else if (mode == 2) begin
            n_layers = $urandom_range(MAX_LAYERS + 1, MAX_LAYERS + 6);
        end else if (mode <= 4) begin
            n_layers = $urandom_range(7, MAX_LAYERS);
        end else begin
            n_layers = $urandom_range(1, 6);
        end
        for (int i = 0; i < n_layers; i++) begin
            keyed = all_white || ($urandom_range(0, 4) == 0);
            if (keyed) begin
                add_layer(8'd255, 8'd255, 8'd255, pick_chan(), i == n_layers - 1,
                          hold && i == 0);
            end else begin
                add_layer(pick_chan(), pick_chan(), pick_chan(), pick_chan(),
                          i == n_layers - 1, hold && i == 0);
            end
        end
    endtask

    // stimulus, reset and end of run
    initial begin
        int next_hold;
        clear_blend();

        // single layers at the extremes, near-white stays counted
        add_layer(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
        add_layer(8'd255, 8'd255, 8'd254, 8'd255, 1'b1, 1'b0);
        // pure white keyed out, alone and in pairs
        add_layer(8'd255, 8'd255, 8'd255, 8'd0, 1'b1, 1'b0);
        add_layer(8'd255, 8'd255, 8'd255, 8'd17, 1'b0, 1'b0);
        add_layer(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
        // white layer ignored, truncating average of two
        add_layer(8'd255, 8'd255, 8'd255, 8'd9, 1'b0, 1'b0);
        add_layer(8'd1, 8'd254, 8'd0, 8'd3, 1'b0, 1'b0);
        add_layer(8'd2, 8'd255, 8'd1, 8'd0, 1'b1, 1'b0);
        // full sums, then one layer too many closing the pixel
        for (int i = 0; i < MAX_LAYERS; i++) begin
            add_layer(8'd255, 8'd254, 8'd255, 8'd255, 1'b0, 1'b0);
        end
        add_layer(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);

        // random pixels, with a few points where the sender drains the block first
        add_random_pixel(1'b1);
        next_hold = 600;
        while (layer_q.size() < ITEM_TARGET) begin
            add_random_pixel(layer_q.size() >= next_hold);
            if (layer_q.size() >= next_hold) begin
                next_hold += 600;
            end
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (layer_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (s_axis_tvalid) begin
                blend_layer(cur_layer);
                sent_cnt++;
            end
            if (send_gap != 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (layer_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (layer_q[0].hold && pending_pixels.size() != 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (layer_q.size() > TAIL_ITEMS && (sent_cnt / 150) % 3 != 2 &&
                         $urandom_range(0, 5) == 0) begin
                send_gap      <= $urandom_range(0, 5);
                s_axis_tvalid <= 1'b0;
            end else begin
                cur_layer = layer_q.pop_front();
                s_axis_tdata  <= cur_layer.pix;
                s_axis_tlast  <= cur_layer.last;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // output monitor and checker
    always @(posedge i_clk) begin
        blend_px_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                recv_cnt++;
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected result data %h user %b", $realtime,
                             m_axis_tdata, m_axis_tuser);
                    err_cnt++;
                end else begin
                    want = pending_pixels.pop_front();
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (m_axis_tdata[c*CH_W +: CH_W] !== want.pix[c]) begin
                            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime,
                                     chan_name[c], want.pix[c], m_axis_tdata[c*CH_W +: CH_W]);
                            err_cnt++;
                        end
                    end
                    if (m_axis_tuser[0] !== want.all_keyed) begin
                        $display("%0t: all_keyed mismatch, expected %b actual %b", $realtime,
                                 want.all_keyed, m_axis_tuser[0]);
                        err_cnt++;
                    end
                    if (m_axis_tuser[1] !== want.overflow) begin
                        $display("%0t: layer_overflow mismatch, expected %b actual %b",
                                 $realtime, want.overflow, m_axis_tuser[1]);
                        err_cnt++;
                    end
                end
            end
            // random stall bursts, none in the tail of the run
            if (recv_stall != 0) begin
                recv_stall    <= recv_stall - 1;
                m_axis_tready <= 1'b0;
            end else if (layer_q.size() > TAIL_ITEMS && (recv_cnt / 40) % 3 != 1 &&
                         $urandom_range(0, 3) == 0) begin
                recv_stall    <= $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout", $realtime);
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
